// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the lens mesh vertex RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset
`define AST_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Same-cycle implication
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/lensdm_pkg.sv =====
// Package: types, constants and fixed-point helpers of the lens mesh vertex block
`timescale 1ns / 1ps
package lensdm_pkg;

  localparam int FRAC_BITS = 24;
  localparam int MAX_KNOTS = 16;
  localparam int MAX_TILES = 64;
  localparam int KIDX_W    = $clog2(MAX_KNOTS);
  localparam int TIDX_W    = $clog2(MAX_TILES);
  localparam int ABR_N     = 4;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int NSTAGE    = 18;
  localparam int RCP_BITS  = 32;
  localparam int RCP_SH    = RCP_BITS - FRAC_BITS;

  localparam logic signed [63:0] QONE = 64'sd1 <<< FRAC_BITS;

  localparam logic [1:0] KIND_KNOT = 2'd0;
  localparam logic [1:0] KIND_ABR  = 2'd1;
  localparam logic [1:0] KIND_VTX  = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  localparam logic [2:0] CFG_TILES_WIDE = 3'd0;
  localparam logic [2:0] CFG_TILES_HIGH = 3'd1;
  localparam logic [2:0] CFG_SHIFT_VIEW = 3'd2;
  localparam logic [2:0] CFG_SCALE_X    = 3'd3;
  localparam logic [2:0] CFG_SCALE_Y    = 3'd4;
  localparam logic [2:0] CFG_KNOT_COUNT = 3'd5;
  localparam logic [2:0] CFG_COMPARE    = 3'd6;

  typedef enum logic [3:0] {
    OP_NONE = 4'b0001,
    OP_KNOT = 4'b0010,
    OP_ABR  = 4'b0100,
    OP_VTX  = 4'b1000
  } op_t;

  typedef struct packed {
    logic [6:0]         tw;
    logic [6:0]         th;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic [4:0]         nk;
    logic               cmp;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic               eye;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic [31:0]        qx0;
    logic [31:0]        qy0;
    logic signed [31:0] sh;
    logic [12:0]        vidx;
  } fr_t;

  typedef struct packed {
    op_t                op;
    logic               eye;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic [31:0]        qx;
    logic [31:0]        qy;
    logic signed [31:0] sh;
    logic [12:0]        vidx;
    logic signed [31:0] ux, uy, dx, dy, tx, ty, t2x, t2y, rsq;
    logic signed [63:0] scaled;
    logic [KIDX_W-1:0]  k;
    logic               z2, z3;
    logic signed [31:0] t, c0, c1, c2, c3, ar, ab, fr, fb;
    logic signed [31:0] p0, m0, p1, m1, omt, a, b, pa, mt;
    logic signed [31:0] s1, p1b, m1o, s1x, s2a, s1f, s2y, s2f, sc, cr, cb;
    logic signed [31:0] r0, r1, r2, r3, r4, r5;
  } vx_t;

  function automatic logic signed [63:0] sx(input logic signed [31:0] v);
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                             input logic signed [31:0] y);
    logic signed [63:0] p;
    p = sx(x) * sx(y);
    return sat32(p >>> FRAC_BITS);
  endfunction

  // floor(2^RCP_BITS / d), evaluated at elaboration
  function automatic logic [RCP_BITS:0] recip_c(input int d);
    logic [RCP_BITS+1:0] rem;
    logic [RCP_BITS:0]   q;
    rem = '0;
    q   = '0;
    for (int i = RCP_BITS; i >= 0; i--) begin
      rem = {rem[RCP_BITS:0], (i == RCP_BITS)};
      if (rem >= (RCP_BITS+2)'(d)) begin
        rem  = rem - (RCP_BITS+2)'(d);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== rtl/core/lensdm_in_if.sv =====
// Interface: vertex and table-write item channel
`timescale 1ns / 1ps
interface lensdm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic               eye;
  logic [6:0]         tile_col;
  logic [6:0]         tile_row;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_value;

  modport source (output valid, kind, eye, tile_col, tile_row, entry_index, entry_value,
                  input ready);
  modport sink   (input valid, kind, eye, tile_col, tile_row, entry_index, entry_value,
                  output ready);
endinterface

// ===== rtl/core/lensdm_out_if.sv =====
// Interface: distorted vertex result channel
`timescale 1ns / 1ps
interface lensdm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] red_x;
  logic signed [31:0] red_y;
  logic signed [31:0] green_x;
  logic signed [31:0] green_y;
  logic signed [31:0] blue_x;
  logic signed [31:0] blue_y;
  logic [12:0]        vertex_index;
  logic               which_eye;

  modport source (output valid, red_x, red_y, green_x, green_y, blue_x, blue_y,
                  vertex_index, which_eye, input ready);
  modport sink   (input valid, red_x, red_y, green_x, green_y, blue_x, blue_y,
                  vertex_index, which_eye, output ready);
endinterface

// ===== rtl/core/lensdm_ram.sv =====
// Generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps
module lensdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule

// ===== rtl/core/lensdm_front.sv =====
// Front end: configuration registers, item classification and divisor reciprocals
`timescale 1ns / 1ps
module lensdm_front import lensdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lensdm_in_if.sink   in_vtx,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output fr_t         q_item,
  output cfg_t        cfg
);
  logic [6:0]         tiles_wide_r, tiles_high_r;
  logic signed [31:0] shift_view_r, scale_x_r, scale_y_r;
  logic [4:0]         knot_count_r;
  logic               compare_r;
  logic [RCP_BITS:0]  rtab [MAX_TILES];
  logic [6:0]         tw_m1, th_m1;
  logic [RCP_BITS+7:0] px, py;
  logic [13:0]        vi;
  op_t                op;

  for (genvar g = 0; g < MAX_TILES; g++) begin : g_rcp
    localparam logic [RCP_BITS:0] RV = recip_c(g + 1);
    assign rtab[g] = RV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_wide_r <= 7'd30;
      tiles_high_r <= 7'd33;
      shift_view_r <= '0;
      scale_x_r    <= 32'sd16777216;
      scale_y_r    <= 32'sd16777216;
      knot_count_r <= 5'd11;
      compare_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILES_WIDE: tiles_wide_r <= cfg_wdata[6:0];
        CFG_TILES_HIGH: tiles_high_r <= cfg_wdata[6:0];
        CFG_SHIFT_VIEW: shift_view_r <= cfg_wdata;
        CFG_SCALE_X:    scale_x_r    <= cfg_wdata;
        CFG_SCALE_Y:    scale_y_r    <= cfg_wdata;
        CFG_KNOT_COUNT: knot_count_r <= cfg_wdata[4:0];
        CFG_COMPARE:    compare_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.tw = (tiles_wide_r == 7'd0) ? 7'd1 :
             (tiles_wide_r > 7'(MAX_TILES)) ? 7'(MAX_TILES) : tiles_wide_r;
    cfg.th = (tiles_high_r == 7'd0) ? 7'd1 :
             (tiles_high_r > 7'(MAX_TILES)) ? 7'(MAX_TILES) : tiles_high_r;
    cfg.scale_x    = scale_x_r;
    cfg.scale_y    = scale_y_r;
    cfg.nk = (knot_count_r < 5'd3) ? 5'd3 :
             (knot_count_r > 5'(MAX_KNOTS)) ? 5'(MAX_KNOTS) : knot_count_r;
    cfg.cmp = compare_r;
  end

  always_comb begin
    case (in_vtx.kind)
      KIND_KNOT: op = OP_KNOT;
      KIND_ABR:  op = (in_vtx.entry_index < 4'(ABR_N)) ? OP_ABR : OP_NONE;
      KIND_VTX:  op = OP_VTX;
      default:   op = OP_NONE;
    endcase
    tw_m1 = cfg.tw - 7'd1;
    th_m1 = cfg.th - 7'd1;
    px = (RCP_BITS+8)'(in_vtx.tile_col) * (RCP_BITS+8)'(rtab[tw_m1[TIDX_W-1:0]]);
    py = (RCP_BITS+8)'(in_vtx.tile_row) * (RCP_BITS+8)'(rtab[th_m1[TIDX_W-1:0]]);
    vi = 14'(in_vtx.tile_row) * 14'(cfg.tw + 7'd1) + 14'(in_vtx.tile_col);

    q_item.op   = op;
    q_item.eye  = in_vtx.eye;
    q_item.col  = in_vtx.tile_col;
    q_item.row  = in_vtx.tile_row;
    q_item.idx  = in_vtx.entry_index;
    q_item.val  = in_vtx.entry_value;
    q_item.qx0  = 32'(px >> RCP_SH);
    q_item.qy0  = 32'(py >> RCP_SH);
    q_item.sh   = in_vtx.eye ? sat32(-sx(shift_view_r)) : shift_view_r;
    q_item.vidx = vi[12:0];
  end

  assign in_vtx.ready = !q_full;
  assign q_push       = in_vtx.valid && !q_full && (op != OP_NONE);
endmodule

// ===== rtl/core/lensdm_queue.sv =====
// Short item queue between front end and back pipeline
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lensdm_queue import lensdm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  fr_t  push_item,
  output logic full,
  input  logic pop,
  output logic empty,
  output fr_t  head
);
  fr_t            mem_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && !empty)) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop && !empty) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop && !empty) rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_item;
  end

  `AST_IMPLY(a_no_push_full, clk, rst_n, full, !push)
  `AST_NEXT(a_pop_drains, clk, rst_n, pop && !empty && !push, cnt_r + 1'b1 == $past(cnt_r))
endmodule

// ===== rtl/core/lensdm_back.sv =====
// Back pipeline: angles, radius, spline, aberration and channel scaling
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lensdm_back import lensdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  fr_t         q_head,
  output logic        q_pop,
  lensdm_out_if.source out_res
);
  vx_t                st_r   [NSTAGE];
  vx_t                st_nxt [NSTAGE];
  logic [NSTAGE-1:0]  vld_r;
  logic               en;
  logic signed [31:0] abr_r [ABR_N];
  logic [31:0]        rq [4];
  logic [KIDX_W-1:0]  raddr [4];
  logic               knot_we, abr_we;
  logic [KIDX_W-1:0]  nm1;

  logic [32:0]        qx1, qy1;
  logic [39:0]        mx, my, nx, ny;
  logic signed [63:0] kr;
  logic signed [31:0] km, kk, k1, k2;

  assign nm1 = KIDX_W'(cfg.nk - 5'd1);
  assign out_res.valid = vld_r[NSTAGE-1] && (st_r[NSTAGE-1].op == OP_VTX);
  assign en    = !out_res.valid || out_res.ready;
  assign q_pop = en && !q_empty;

  assign knot_we = en && vld_r[6] && (st_r[6].op == OP_KNOT);
  assign abr_we  = en && vld_r[6] && (st_r[6].op == OP_ABR);

  for (genvar p = 0; p < 4; p++) begin : g_knot
    lensdm_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_ram (
      .clk   (clk),
      .we    (knot_we),
      .waddr (st_r[6].idx[KIDX_W-1:0]),
      .wdata (st_r[6].val),
      .re    (en),
      .raddr (raddr[p]),
      .rdata (rq[p])
    );
  end

  always_comb begin
    st_nxt[0] = '0;
    for (int j = 1; j < NSTAGE; j++) st_nxt[j] = st_r[j-1];

    st_nxt[0].op   = q_head.op;
    st_nxt[0].eye  = q_head.eye;
    st_nxt[0].col  = q_head.col;
    st_nxt[0].row  = q_head.row;
    st_nxt[0].idx  = q_head.idx;
    st_nxt[0].val  = q_head.val;
    st_nxt[0].sh   = q_head.sh;
    st_nxt[0].vidx = q_head.vidx;
    qx1 = 33'(q_head.qx0) + 33'd1;
    qy1 = 33'(q_head.qy0) + 33'd1;
    mx  = 40'(qx1) * 40'(cfg.tw);
    my  = 40'(qy1) * 40'(cfg.th);
    nx  = 40'(q_head.col) << FRAC_BITS;
    ny  = 40'(q_head.row) << FRAC_BITS;
    st_nxt[0].qx = (mx <= nx) ? qx1[31:0] : q_head.qx0;
    st_nxt[0].qy = (my <= ny) ? qy1[31:0] : q_head.qy0;

    st_nxt[1].ux = sat32(sx(st_r[0].sh) + $signed({32'd0, st_r[0].qx}));
    st_nxt[1].uy = sat32(QONE - $signed({32'd0, st_r[0].qy}));

    st_nxt[2].dx = sat32((sx(st_r[1].ux) <<< 1) - QONE);
    st_nxt[2].dy = sat32((sx(st_r[1].uy) <<< 1) - QONE);

    st_nxt[3].tx = qmul(st_r[2].dx, cfg.scale_x);
    st_nxt[3].ty = qmul(st_r[2].dy, cfg.scale_y);

    st_nxt[4].t2x = qmul(st_r[3].tx, st_r[3].tx);
    st_nxt[4].t2y = qmul(st_r[3].ty, st_r[3].ty);

    st_nxt[5].rsq = sat32(sx(st_r[4].t2x) + sx(st_r[4].t2y));

    st_nxt[6].scaled = $signed({{(64-KIDX_W){1'b0}}, nm1}) * sx(st_r[5].rsq);

    kr = st_r[6].scaled >>> FRAC_BITS;
    if (kr < 0) st_nxt[7].k = '0;
    else if (kr > $signed({{(64-KIDX_W){1'b0}}, nm1})) st_nxt[7].k = nm1;
    else st_nxt[7].k = kr[KIDX_W-1:0];
    st_nxt[7].t  = sat32(st_r[6].scaled -
                         ($signed({{(64-KIDX_W){1'b0}}, st_nxt[7].k}) <<< FRAC_BITS));
    st_nxt[7].z2 = (st_nxt[7].k >= KIDX_W'(MAX_KNOTS - 1));
    st_nxt[7].z3 = (st_nxt[7].k >= KIDX_W'(MAX_KNOTS - 2));
    st_nxt[7].c0 = abr_r[0];
    st_nxt[7].c1 = abr_r[1];
    st_nxt[7].c2 = abr_r[2];
    st_nxt[7].c3 = abr_r[3];
    raddr[0] = st_nxt[7].k - 1'b1;
    raddr[1] = st_nxt[7].k;
    raddr[2] = st_nxt[7].k + 1'b1;
    raddr[3] = st_nxt[7].k + 2'd2;

    km = rq[0];
    kk = rq[1];
    k1 = st_r[7].z2 ? 32'sd0 : rq[2];
    k2 = st_r[7].z3 ? 32'sd0 : rq[3];
    st_nxt[8].ar = qmul(st_r[7].rsq, st_r[7].c1);
    st_nxt[8].ab = qmul(st_r[7].rsq, st_r[7].c3);
    st_nxt[8].p0 = kk;
    if (st_r[7].k == '0) begin
      st_nxt[8].m0 = sat32(sx(k1) - sx(kk));
      st_nxt[8].p1 = k1;
      st_nxt[8].m1 = sat32((sx(k2) - sx(kk)) >>> 1);
    end else if ({1'b0, st_r[7].k} < (cfg.nk - 5'd2)) begin
      st_nxt[8].m0 = sat32((sx(k1) - sx(km)) >>> 1);
      st_nxt[8].p1 = k1;
      st_nxt[8].m1 = sat32((sx(k2) - sx(kk)) >>> 1);
    end else if ({1'b0, st_r[7].k} == (cfg.nk - 5'd2)) begin
      st_nxt[8].m0 = sat32((sx(k1) - sx(km)) >>> 1);
      st_nxt[8].p1 = k1;
      st_nxt[8].m1 = sat32(sx(k1) - sx(kk));
    end else begin
      st_nxt[8].m0 = sat32(sx(kk) - sx(km));
      st_nxt[8].p1 = sat32(sx(kk) + sx(st_nxt[8].m0));
      st_nxt[8].m1 = st_nxt[8].m0;
    end

    st_nxt[9].omt = sat32(QONE - sx(st_r[8].t));
    st_nxt[9].a   = sat32(QONE + (sx(st_r[8].t) <<< 1));
    st_nxt[9].fr  = sat32(QONE + sx(st_r[8].c0) + sx(st_r[8].ar));
    st_nxt[9].fb  = sat32(QONE + sx(st_r[8].c2) + sx(st_r[8].ab));

    st_nxt[10].pa = qmul(st_r[9].p0, st_r[9].a);
    st_nxt[10].mt = qmul(st_r[9].m0, st_r[9].t);
    st_nxt[10].b  = sat32(QONE + (sx(st_r[9].omt) <<< 1));

    st_nxt[11].s1  = sat32(sx(st_r[10].pa) + sx(st_r[10].mt));
    st_nxt[11].p1b = qmul(st_r[10].p1, st_r[10].b);
    st_nxt[11].m1o = qmul(st_r[10].m1, st_r[10].omt);

    st_nxt[12].s1x = qmul(st_r[11].s1, st_r[11].omt);
    st_nxt[12].s2a = sat32(sx(st_r[11].p1b) - sx(st_r[11].m1o));

    st_nxt[13].s1f = qmul(st_r[12].s1x, st_r[12].omt);
    st_nxt[13].s2y = qmul(st_r[12].s2a, st_r[12].t);

    st_nxt[14].s2f = qmul(st_r[13].s2y, st_r[13].t);

    st_nxt[15].sc = sat32(sx(st_r[14].s1f) + sx(st_r[14].s2f));

    st_nxt[16].cr = qmul(st_r[15].sc, st_r[15].fr);
    st_nxt[16].cb = qmul(st_r[15].sc, st_r[15].fb);

    if (cfg.cmp) begin
      st_nxt[17].r0 = st_r[16].tx;
      st_nxt[17].r1 = st_r[16].ty;
      st_nxt[17].r2 = st_r[16].tx;
      st_nxt[17].r3 = st_r[16].ty;
      st_nxt[17].r4 = st_r[16].tx;
      st_nxt[17].r5 = st_r[16].ty;
    end else begin
      st_nxt[17].r0 = qmul(st_r[16].cr, st_r[16].tx);
      st_nxt[17].r1 = qmul(st_r[16].cr, st_r[16].ty);
      st_nxt[17].r2 = qmul(st_r[16].sc, st_r[16].tx);
      st_nxt[17].r3 = qmul(st_r[16].sc, st_r[16].ty);
      st_nxt[17].r4 = qmul(st_r[16].cb, st_r[16].tx);
      st_nxt[17].r5 = qmul(st_r[16].cb, st_r[16].ty);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NSTAGE; j++) st_r[j] <= st_nxt[j];
    end
    if (abr_we) abr_r[st_r[6].idx[1:0]] <= st_r[6].val;
  end

  assign out_res.red_x        = st_r[NSTAGE-1].r0;
  assign out_res.red_y        = st_r[NSTAGE-1].r1;
  assign out_res.green_x      = st_r[NSTAGE-1].r2;
  assign out_res.green_y      = st_r[NSTAGE-1].r3;
  assign out_res.blue_x       = st_r[NSTAGE-1].r4;
  assign out_res.blue_y       = st_r[NSTAGE-1].r5;
  assign out_res.vertex_index = st_r[NSTAGE-1].vidx;
  assign out_res.which_eye    = st_r[NSTAGE-1].eye;

  `AST_NEXT(a_stall_freezes, clk, rst_n, !en, $stable(vld_r))
  `AST_NEXT(a_pop_enters, clk, rst_n, q_pop, vld_r[0])
endmodule

// ===== rtl/core/lens_distortion_mesh_vertex.sv =====
// Top level: lens distortion mesh vertex generator
//
//  channel   dir  handshake          payload
//  in_vtx    in   valid/ready        kind, eye, tile_col, tile_row, entry_index, entry_value
//  out_res   out  valid/ready        red/green/blue x,y, vertex_index, which_eye
//  cfg       in   cfg_we, no wait    cfg_index, cfg_wdata
//
// One item per cycle sustained while out_res is not stalled; a vertex result leaves through
// the 18-stage back pipeline behind the one-entry-per-cycle queue.
// Reset is synchronous, active low; no clearing pass, tables are written by items.
// A stalled output freezes the back pipeline; the 4-entry queue keeps taking items
// until full, then in_vtx.ready drops. Table writes take effect in item order.
`timescale 1ns / 1ps
module lens_distortion_mesh_vertex import lensdm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lensdm_in_if.sink   in_vtx,
  lensdm_out_if.source out_res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  cfg_t cfg;
  fr_t  q_item, q_head;
  logic q_push, q_full, q_pop, q_empty;

  lensdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vtx    (in_vtx),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item),
    .cfg       (cfg)
  );

  lensdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  lensdm_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_res (out_res)
  );
endmodule

// ===== tb/testbench.sv =====
// Testbench for lens_distortion_mesh_vertex: table loads, config sweeps, random vertices
`timescale 1ns / 1ps
module testbench import lensdm_pkg::*; ();

  typedef struct {
    longint rx, ry, gx, gy, bx, by;
    int     vidx;
    bit     eye;
  } vertex_res_t;

  class mesh_scoreboard;
    int          tw = 30, th = 33, nk = 11;
    bit          cmp = 0;
    longint      shift = 0, scx = 64'sd1 << 24, scy = 64'sd1 << 24;
    longint      knots[16];
    longint      abr[4];
    vertex_res_t pending_q[$];
    int          errors = 0;
    int          vertices = 0;

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qm(longint a, longint b);
      return sat((a * b) >>> FRAC_BITS);
    endfunction

    function longint kn(longint i);
      if (i < 0 || i > 15) return 0;
      return knots[i];
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        CFG_TILES_WIDE: tw = int'(v[6:0]);
        CFG_TILES_HIGH: th = int'(v[6:0]);
        CFG_SHIFT_VIEW: shift = longint'($signed(v));
        CFG_SCALE_X:    scx = longint'($signed(v));
        CFG_SCALE_Y:    scy = longint'($signed(v));
        CFG_KNOT_COUNT: nk = int'(v[4:0]);
        CFG_COMPARE:    cmp = v[0];
        default: ;
      endcase
    endfunction

    function longint radial(longint x, longint n);
      longint scaled, k, t, omt, p0, p1, m0, m1, a, b, s1, s2;
      longint one;
      one = 64'sd1 << FRAC_BITS;
      scaled = (n - 1) * x;
      k = scaled >>> FRAC_BITS;
      if (k < 0) k = 0;
      if (k > n - 1) k = n - 1;
      t = sat(scaled - k * one);
      if (k == 0) begin
        p0 = kn(0); m0 = sat(kn(1) - kn(0)); p1 = kn(1);
        m1 = sat((kn(2) - kn(0)) >>> 1);
      end else if (k < n - 2) begin
        p0 = kn(k); m0 = sat((kn(k + 1) - kn(k - 1)) >>> 1); p1 = kn(k + 1);
        m1 = sat((kn(k + 2) - kn(k)) >>> 1);
      end else if (k == n - 2) begin
        p0 = kn(k); m0 = sat((kn(k + 1) - kn(k - 1)) >>> 1); p1 = kn(k + 1);
        m1 = sat(kn(k + 1) - kn(k));
      end else begin
        p0 = kn(k); m0 = sat(kn(k) - kn(k - 1)); p1 = sat(p0 + m0); m1 = m0;
      end
      omt = sat(one - t);
      a = sat(one + 2 * t);
      s1 = sat(qm(p0, a) + qm(m0, t));
      s1 = qm(qm(s1, omt), omt);
      b = sat(one + 2 * omt);
      s2 = sat(qm(p1, b) - qm(m1, omt));
      s2 = qm(qm(s2, t), t);
      return sat(s1 + s2);
    endfunction

    function void note_item(logic [1:0] kind, bit eye, int col, int row, int idx,
                            logic [31:0] val);
      longint      w, h, n, sh, ux, uy, tx, ty, rsq, sc, cr, cb, one;
      vertex_res_t e;
      one = 64'sd1 << FRAC_BITS;
      if (kind == KIND_KNOT) begin
        knots[idx] = longint'($signed(val));
        return;
      end
      if (kind == KIND_ABR) begin
        if (idx < 4) abr[idx] = longint'($signed(val));
        return;
      end
      if (kind != KIND_VTX) return;
      w = (tw < 1) ? 1 : (tw > MAX_TILES) ? MAX_TILES : tw;
      h = (th < 1) ? 1 : (th > MAX_TILES) ? MAX_TILES : th;
      n = (nk < 3) ? 3 : (nk > MAX_KNOTS) ? MAX_KNOTS : nk;
      sh = eye ? sat(-shift) : shift;
      ux = sat(sh + ((longint'(col) << FRAC_BITS) / w));
      uy = sat(one - ((longint'(row) << FRAC_BITS) / h));
      tx = qm(sat(2 * ux - one), scx);
      ty = qm(sat(2 * uy - one), scy);
      rsq = sat(qm(tx, tx) + qm(ty, ty));
      if (cmp) begin
        e.rx = tx; e.ry = ty; e.gx = tx; e.gy = ty; e.bx = tx; e.by = ty;
      end else begin
        sc = radial(rsq, n);
        cr = qm(sc, sat(one + abr[0] + qm(rsq, abr[1])));
        cb = qm(sc, sat(one + abr[2] + qm(rsq, abr[3])));
        e.rx = qm(cr, tx); e.ry = qm(cr, ty);
        e.gx = qm(sc, tx); e.gy = qm(sc, ty);
        e.bx = qm(cb, tx); e.by = qm(cb, ty);
      end
      e.vidx = int'((row * (w + 1) + col) & 64'h1fff);
      e.eye = eye;
      pending_q.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(longint rx, longint ry, longint gx, longint gy, longint bx,
                      longint by, int vidx, bit eye);
      vertex_res_t e;
      if (pending_q.size() == 0) begin
        report("unexpected vertex", vidx, -1);
        return;
      end
      e = pending_q.pop_front();
      vertices++;
      if (rx != e.rx) report("red_x", rx, e.rx);
      if (ry != e.ry) report("red_y", ry, e.ry);
      if (gx != e.gx) report("green_x", gx, e.gx);
      if (gy != e.gy) report("green_y", gy, e.gy);
      if (bx != e.bx) report("blue_x", bx, e.bx);
      if (by != e.by) report("blue_y", by, e.by);
      if (vidx != e.vidx) report("vertex_index", vidx, e.vidx);
      if (eye != e.eye) report("which_eye", eye, e.eye);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  bit          steady;
  int          cycle;
  int          items_sent;

  lensdm_in_if  in_vtx();
  lensdm_out_if out_res();

  mesh_scoreboard sb = new();

  lens_distortion_mesh_vertex DUT (
    .clk(clk), .rst_n(rst_n), .in_vtx(in_vtx), .out_res(out_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  always @(posedge clk) begin
    out_res.ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);
  end

  always @(posedge clk) begin
    if (rst_n && in_vtx.valid && in_vtx.ready)
      sb.note_item(in_vtx.kind, in_vtx.eye, int'(in_vtx.tile_col), int'(in_vtx.tile_row),
                   int'(in_vtx.entry_index), in_vtx.entry_value);
    if (rst_n && out_res.valid && out_res.ready)
      sb.check_result(longint'(out_res.red_x), longint'(out_res.red_y),
                      longint'(out_res.green_x), longint'(out_res.green_y),
                      longint'(out_res.blue_x), longint'(out_res.blue_y),
                      int'(out_res.vertex_index), out_res.which_eye);
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 300000) begin
      $display("[lens_distortion_mesh_vertex] ERROR");
      $finish;
    end
  end

  task send_item(logic [1:0] kind, bit eye, int col, int row, int idx, logic [31:0] val);
    while (!steady && $urandom_range(99) < 17) begin
      in_vtx.valid <= 1'b0;
      @(posedge clk);
    end
    in_vtx.valid <= 1'b1;
    in_vtx.kind <= kind;
    in_vtx.eye <= eye;
    in_vtx.tile_col <= 7'(col);
    in_vtx.tile_row <= 7'(row);
    in_vtx.entry_index <= 4'(idx);
    in_vtx.entry_value <= val;
    @(posedge clk);
    while (!in_vtx.ready) @(posedge clk);
    items_sent++;
  endtask

  task write_regs(int w, int h, logic [31:0] shv, logic [31:0] sx_v, logic [31:0] sy_v,
                  int n, bit c);
    logic [31:0] vals[7];
    in_vtx.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    vals = '{w, h, shv, sx_v, sy_v, n, 32'(c)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      sb.set_reg(3'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function logic [31:0] knot_value(int i);
    return 32'(16777216 + i * 300000 + $signed($urandom_range(400000)) - 200000);
  endfunction

  task random_items(int count);
    int r, col, row;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      col = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(sb.tw);
      row = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(sb.th);
      if (r < 76)
        send_item(KIND_VTX, 1'($urandom_range(1)), col, row, $urandom_range(15), $urandom);
      else if (r < 86)
        send_item(KIND_KNOT, 1'($urandom_range(1)), col, row, $urandom_range(15),
                  ($urandom_range(19) == 0) ? $urandom : knot_value($urandom_range(15)));
      else if (r < 95)
        send_item(KIND_ABR, 1'($urandom_range(1)), col, row, $urandom_range(15),
                  ($urandom_range(19) == 0) ? $urandom
                                            : 32'($signed($urandom_range(2000000)) - 1000000));
      else
        send_item(KIND_RSVD, 1'($urandom_range(1)), $urandom_range(127), $urandom_range(127),
                  $urandom_range(15), $urandom);
    end
    in_vtx.valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_vtx.valid = 1'b0; in_vtx.kind = '0; in_vtx.eye = 1'b0; in_vtx.tile_col = '0;
    in_vtx.tile_row = '0; in_vtx.entry_index = '0; in_vtx.entry_value = '0;
    steady = 1'b0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 16; i++) send_item(KIND_KNOT, 1'b0, 0, 0, i, knot_value(i));
    send_item(KIND_ABR, 1'b1, 127, 127, 0, 32'h0002_0000);
    send_item(KIND_ABR, 1'b0, 0, 0, 1, 32'hfff0_0000);
    send_item(KIND_ABR, 1'b0, 0, 0, 2, 32'hfffe_0000);
    send_item(KIND_ABR, 1'b0, 0, 0, 3, 32'h0010_0000);
    send_item(KIND_ABR, 1'b0, 0, 0, 9, 32'h7fff_ffff);
    send_item(KIND_RSVD, 1'b1, 127, 127, 15, 32'hffff_ffff);
    send_item(KIND_VTX, 1'b0, 0, 0, 0, 0);
    send_item(KIND_VTX, 1'b1, 30, 33, 15, 0);
    send_item(KIND_VTX, 1'b0, 127, 127, 0, 0);
    in_vtx.valid <= 1'b0;

    write_regs(1, 1, 0, 32'h0100_0000, 32'h0100_0000, 3, 1'b0);
    random_items(70);
    write_regs(64, 64, 32'h0033_3333, 32'h00c0_0000, 32'h0140_0000, 16, 1'b0);
    random_items(70);
    write_regs(0, 127, 32'hffcc_cccd, 32'h0100_0000, 32'h00e0_0000, 0, 1'b1);
    random_items(60);
    write_regs(127, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31, 1'b0);
    random_items(50);
    write_regs(20, 20, 32'h7fff_ffff, 32'h0200_0000, 32'h0200_0000, 8, 1'b0);
    random_items(50);
    steady = 1'b1;
    write_regs(30, 33, 32'h0010_0000, 32'h0110_0000, 32'h0110_0000, 11, 1'b0);
    random_items(100);
    steady = 1'b0;
    for (int p = 0; p < 4; p++) begin
      write_regs($urandom_range(1, 64), $urandom_range(1, 64),
                 32'($signed($urandom_range(6000000)) - 3000000),
                 32'($urandom_range(8000000, 30000000)), 32'($urandom_range(8000000, 30000000)),
                 $urandom_range(3, 16), 1'($urandom_range(1)));
      random_items(55);
    end

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d input items and %0d vertex results over 10 register settings",
             items_sent, sb.vertices);
    $display("tables reloaded at random; compare mode, clamped counts and saturation included");
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("[lens_distortion_mesh_vertex] OK");
    else
      $display("[lens_distortion_mesh_vertex] ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lensdm_pkg.sv
rtl/core/lensdm_in_if.sv
rtl/core/lensdm_out_if.sv
rtl/core/lensdm_ram.sv
rtl/core/lensdm_front.sv
rtl/core/lensdm_queue.sv
rtl/core/lensdm_back.sv
rtl/core/lens_distortion_mesh_vertex.sv
tb/testbench.sv
